### rtl/core/wics_pkg.sv
// Package for the windowed I/O completion statistics unit.
// Holds command, register and metric codes, sequencer types and opcode decode.
// No dependencies.
`default_nettype none

package wics_pkg;

   // field widths
   localparam int CMD_W     = 2;
   localparam int OPC_W     = 8;
   localparam int XFER_W    = 31;
   localparam int TIME_W    = 64;
   localparam int QSEL_W    = 2;
   localparam int TOT_W     = 64;
   localparam int VALUE_W   = 44;
   localparam int CSR_IDX_W = 3;

   // totals are reported in units of 2^20
   localparam int METRIC_SHIFT = 20;

   // fixed register file of window lengths, one per possible window
   localparam int LEN_REGS = 4;
   localparam int MET_NUM  = 4;
   localparam logic [TIME_W-1:0] LENGTH_RESET = 64'd1000000000;

   // command codes
   localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN3   = 3'd4;

   // metric slots: {direction, kind}
   localparam logic [QSEL_W-1:0] MET_RD_BYTES = 2'd0;
   localparam logic [QSEL_W-1:0] MET_RD_TIME  = 2'd1;
   localparam logic [QSEL_W-1:0] MET_WR_BYTES = 2'd2;
   localparam logic [QSEL_W-1:0] MET_WR_TIME  = 2'd3;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LAT   = 6'b000010,
      ST_ELAP  = 6'b000100,
      ST_CMP   = 6'b001000,
      ST_BYTES = 6'b010000,
      ST_LACC  = 6'b100000
   } wics_state_type;

   // step strobes from the sequencer to the datapath
   typedef struct packed {
      logic busy;
      logic st_lat;
      logic st_elap;
      logic st_cmp;
      logic st_bytes;
      logic st_lacc;
   } wics_ctl_type;

   function automatic logic is_read_op(input logic [OPC_W-1:0] opc);
      is_read_op = (opc inside {8'h08, 8'h28, 8'h88});
   endfunction

   function automatic logic is_write_op(input logic [OPC_W-1:0] opc);
      is_write_op = (opc inside {8'h0A, 8'h2A, 8'h8A});
   endfunction

endpackage

`default_nettype wire

### rtl/core/wics_alu.sv
// Shared 64-bit add/subtract unit of the statistics unit.
// Carry out on subtract is high when a >= b (no borrow). Uses wics_pkg.
`default_nettype none

module wics_alu (
   input  wire logic [wics_pkg::TIME_W-1:0] op_a,
   input  wire logic [wics_pkg::TIME_W-1:0] op_b,
   input  wire logic                        op_sub,
   output logic      [wics_pkg::TIME_W-1:0] sum,
   output logic                            carry
);
   import wics_pkg::*;

   logic [TIME_W:0] full;
   logic [TIME_W-1:0] b_eff;

   // a + b, or a + ~b + 1 for subtract
   assign b_eff = op_sub ? ~op_b : op_b;
   assign full  = {1'b0, op_a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, op_sub};
   assign sum   = full[TIME_W-1:0];
   assign carry = full[TIME_W];

endmodule

`default_nettype wire

### rtl/core/wics_seq.sv
// Step sequencer of the statistics unit: latency, then four steps per window.
// Drives the window counter and the step strobes. Uses wics_pkg.
`default_nettype none

module wics_seq #(
   parameter int NUM_WINDOWS = 4,
   parameter int WIN_W       = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output wics_pkg::wics_ctl_type  ctl,
   output logic [WIN_W-1:0]        win
);
   import wics_pkg::*;

   wics_state_type state_ff, state_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic last_win;

   assign last_win = (win_ff == WIN_W'(NUM_WINDOWS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      case (state_ff)
         ST_IDLE: begin
            win_in = '0;
            if (start) begin
               state_in = ST_LAT;
            end
         end
         ST_LAT:   state_in = ST_ELAP;
         ST_ELAP:  state_in = ST_CMP;
         ST_CMP:   state_in = ST_BYTES;
         ST_BYTES: state_in = ST_LACC;
         ST_LACC: begin
            if (last_win) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ELAP;
               win_in   = win_ff + WIN_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         win_ff   <= win_in;
      end
   end

   // strobes
   assign ctl.busy     = (state_ff != ST_IDLE);
   assign ctl.st_lat   = (state_ff == ST_LAT);
   assign ctl.st_elap  = (state_ff == ST_ELAP);
   assign ctl.st_cmp   = (state_ff == ST_CMP);
   assign ctl.st_bytes = (state_ff == ST_BYTES);
   assign ctl.st_lacc  = (state_ff == ST_LACC);
   assign win          = win_ff;

endmodule

`default_nettype wire

### rtl/core/windowed_io_completion_statistics_unit.sv
// Top level of the windowed I/O completion statistics unit.
// Holds registers, window state and totals; uses wics_pkg, wics_alu, wics_seq.
`default_nettype none

//  channel | ports                     | direction | handshake
//  --------+---------------------------+-----------+--------------------------
//  req     | command, opcode, times... | in        | req_valid / req_stall
//  rsp     | metric_value, query_error | out       | rsp_valid / rsp_stall
//  csr     | index, wdata              | in        | csr_valid / csr_ready
//
//  A counted completion word starts the sequencer after acceptance: one
//  shared 64-bit adder computes latency, then the elapsed time, the length
//  compare and two total updates for each window. Queries, clears and
//  ignored words do not start it. A query result waits in an output
//  register; req_stall rises while it is stalled or while busy.
//  Synchronous reset restores register defaults and zeroes all window state.

module windowed_io_completion_statistics_unit #(
   parameter int NUM_WINDOWS = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [wics_pkg::CMD_W-1:0]     req_command,
   input  wire logic [wics_pkg::OPC_W-1:0]     req_scsi_opcode,
   input  wire logic [wics_pkg::XFER_W-1:0]    req_transfer_length,
   input  wire logic [wics_pkg::TIME_W-1:0]    req_issue_time,
   input  wire logic [wics_pkg::TIME_W-1:0]    req_completion_time,
   input  wire logic [wics_pkg::QSEL_W-1:0]    req_query_window,
   input  wire logic [wics_pkg::QSEL_W-1:0]    req_query_metric,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [wics_pkg::VALUE_W-1:0]   rsp_metric_value,
   output logic                                rsp_query_error,
   // register write channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [wics_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [wics_pkg::TOT_W-1:0]     csr_wdata
);
   import wics_pkg::*;

   localparam int WIN_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

   // registers
   logic                  enable_ff;
   logic [TIME_W-1:0]     len_ff [LEN_REGS];

   // window state and totals
   logic [TIME_W-1:0]     start_ff [NUM_WINDOWS];
   logic [TOT_W-1:0]      tot_ff   [NUM_WINDOWS][MET_NUM];

   // latched event
   logic [TIME_W-1:0]     now_ff;
   logic [TIME_W-1:0]     issue_ff;
   logic [XFER_W-1:0]     bytes_ff;
   logic                  wr_ff;
   logic [TIME_W-1:0]     lat_ff;
   logic [TIME_W-1:0]     elapsed_ff;
   logic                  restart_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic                  rsp_error_ff;

   wics_ctl_type          ctl;
   logic [WIN_W-1:0]      win;

   logic                  req_go;
   logic                  ev_go;
   logic                  query_go;
   logic                  clear_go;
   logic                  query_bad;
   logic [WIN_W-1:0]      ridx;
   logic [QSEL_W-1:0]     rmet;
   logic [TOT_W-1:0]      rd_word;
   logic [TIME_W-1:0]     rd_start;
   logic                  restart_now;

   logic [TIME_W-1:0]     alu_a;
   logic [TIME_W-1:0]     alu_b;
   logic                  alu_sub;
   logic [TIME_W-1:0]     alu_sum;
   logic                  alu_carry;

   // handshake
   assign req_stall = ctl.busy || (rsp_valid_ff && rsp_stall);
   assign req_go    = req_valid && !req_stall;
   assign ev_go     = req_go && (req_command == CMD_EVENT) && enable_ff &&
                      (is_read_op(req_scsi_opcode) || is_write_op(req_scsi_opcode));
   assign query_go  = req_go && (req_command == CMD_QUERY);
   assign clear_go  = req_go && (req_command == CMD_CLEAR);
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         for (int i = 0; i < LEN_REGS; i++) begin
            len_ff[i] <= LENGTH_RESET;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_LEN0, CSR_LEN1, CSR_LEN2, CSR_LEN3: begin
               len_ff[2'(csr_index - CSR_LEN0)] <= csr_wdata;
            end
            default: ;
         endcase
      end
   end

   // sequencer
   wics_seq #(
      .NUM_WINDOWS (NUM_WINDOWS),
      .WIN_W       (WIN_W)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (ev_go),
      .ctl   (ctl),
      .win   (win)
   );

   // single read port into window state: query address when idle
   assign ridx     = ctl.busy ? win : req_query_window[WIN_W-1:0];
   assign rmet     = ctl.busy ? {wr_ff, ctl.st_lacc} : req_query_metric;
   assign rd_word  = tot_ff[ridx][rmet];
   assign rd_start = start_ff[ridx];

   // shared adder operand select
   always_comb begin
      alu_a   = now_ff;
      alu_b   = issue_ff;
      alu_sub = 1'b1;
      if (ctl.st_elap) begin
         alu_b = rd_start;
      end else if (ctl.st_cmp) begin
         alu_a = elapsed_ff;
         alu_b = len_ff[2'(win)];
      end else if (ctl.st_bytes) begin
         alu_a   = restart_ff ? '0 : rd_word;
         alu_b   = {{(TIME_W - XFER_W){1'b0}}, bytes_ff};
         alu_sub = 1'b0;
      end else if (ctl.st_lacc) begin
         alu_a   = restart_ff ? '0 : rd_word;
         alu_b   = lat_ff;
         alu_sub = 1'b0;
      end
   end

   wics_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .sum    (alu_sum),
      .carry  (alu_carry)
   );

   // start is unset or later than now (borrow out of now - start)
   assign restart_now = (rd_start == '0) || !alu_carry;

   // event latch and step results
   always_ff @(posedge clock) begin
      if (ev_go) begin
         now_ff   <= req_completion_time;
         issue_ff <= req_issue_time;
         bytes_ff <= req_transfer_length;
         wr_ff    <= is_write_op(req_scsi_opcode);
      end
      if (ctl.st_lat) begin
         lat_ff <= alu_sum;
      end
      if (ctl.st_elap) begin
         restart_ff <= restart_now;
         elapsed_ff <= restart_now ? '0 : alu_sum;
      end
   end

   // window state and totals
   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         for (int w = 0; w < NUM_WINDOWS; w++) begin
            start_ff[w] <= '0;
            for (int m = 0; m < MET_NUM; m++) begin
               tot_ff[w][m] <= '0;
            end
         end
      end else if (ctl.st_elap) begin
         // restart: new start, other direction zeroed
         if (restart_now) begin
            start_ff[win]               <= now_ff;
            tot_ff[win][{~wr_ff, 1'b0}] <= '0;
            tot_ff[win][{~wr_ff, 1'b1}] <= '0;
         end
      end else if (ctl.st_cmp) begin
         // window expired: next event restarts it
         if (alu_carry) begin
            start_ff[win] <= '0;
         end
      end else if (ctl.st_bytes) begin
         tot_ff[win][{wr_ff, 1'b0}] <= alu_sum;
      end else if (ctl.st_lacc) begin
         tot_ff[win][{wr_ff, 1'b1}] <= alu_sum;
      end
   end

   // query answer
   assign query_bad = !enable_ff ||
                      ({1'b0, req_query_window} >= (QSEL_W + 1)'(NUM_WINDOWS));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (query_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (query_go) begin
         rsp_value_ff <= query_bad ? '0 : rd_word[METRIC_SHIFT +: VALUE_W];
         rsp_error_ff <= query_bad;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_metric_value = rsp_value_ff;
   assign rsp_query_error  = rsp_error_ff;

   // checks
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      ctl.busy |-> req_stall)
      else $error("request taken while sequencer busy");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(query_go))
      else $error("response raised without a query");

   a_win_range: assert property (@(posedge clock) disable iff (reset)
      ctl.busy |-> (win <= WIN_W'(NUM_WINDOWS - 1)))
      else $error("window counter out of range");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      clear_go |=> (start_ff[0] == '0) && (tot_ff[0][MET_RD_BYTES] == '0) &&
                   (tot_ff[0][MET_WR_TIME] == '0))
      else $error("clear left window state set");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for windowed_io_completion_statistics_unit.
// Drives request words, predicts window totals and query replies, checks replies.
// Depends on wics_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
   import wics_pkg::*;

   localparam int NUM_WIN = 4;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int HOLD_AT = 200;       // words accepted before the long reply hold-off
   localparam int HOLD_CYCLES = 500;
   localparam int SETTLE_CYCLES = 40;  // settle time for counted completions still in the sequencer

   // counted opcodes and the unused command code
   localparam logic [OPC_W-1:0] OPC_RD6  = 8'h08;
   localparam logic [OPC_W-1:0] OPC_RD10 = 8'h28;
   localparam logic [OPC_W-1:0] OPC_RD16 = 8'h88;
   localparam logic [OPC_W-1:0] OPC_WR6  = 8'h0A;
   localparam logic [OPC_W-1:0] OPC_WR10 = 8'h2A;
   localparam logic [OPC_W-1:0] OPC_WR16 = 8'h8A;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 3'd7;

   typedef logic [63:0] u64_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [OPC_W-1:0]  scsi_opcode;
      logic [XFER_W-1:0] transfer_length;
      logic [TIME_W-1:0] issue_time;
      logic [TIME_W-1:0] completion_time;
      logic [QSEL_W-1:0] query_window;
      logic [QSEL_W-1:0] query_metric;
   } stat_word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] metric;
      logic               flagged;
   } metric_reply_type;

   logic clock = 1'b0;
   logic reset;

   logic                 req_valid;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_command;
   logic [OPC_W-1:0]     req_scsi_opcode;
   logic [XFER_W-1:0]    req_transfer_length;
   logic [TIME_W-1:0]    req_issue_time;
   logic [TIME_W-1:0]    req_completion_time;
   logic [QSEL_W-1:0]    req_query_window;
   logic [QSEL_W-1:0]    req_query_metric;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [VALUE_W-1:0]   rsp_metric_value;
   logic                 rsp_query_error;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TOT_W-1:0]     csr_wdata;

   // predicted unit state
   logic mon_enable;
   u64_type win_len      [NUM_WIN];
   u64_type win_start    [NUM_WIN];
   u64_type rd_bytes_tot [NUM_WIN];
   u64_type rd_lat_tot   [NUM_WIN];
   u64_type wr_bytes_tot [NUM_WIN];
   u64_type wr_lat_tot   [NUM_WIN];

   stat_word_type    pending_words[$];
   metric_reply_type metric_replies[$];
   stat_word_type    cur_word;
   u64_type          trace_now;

   logic        pace_on;
   int unsigned gap_left;
   int unsigned next_gap;
   int unsigned stall_left;
   int unsigned hold_left;
   logic        hold_done;
   int unsigned words_sent;
   int unsigned replies_seen;
   int unsigned replies_flagged;
   int unsigned csr_writes;
   int unsigned fail_count;
   int unsigned cycle_count;

   windowed_io_completion_statistics_unit #(
      .NUM_WINDOWS(NUM_WIN)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_scsi_opcode     (req_scsi_opcode),
      .req_transfer_length (req_transfer_length),
      .req_issue_time      (req_issue_time),
      .req_completion_time (req_completion_time),
      .req_query_window    (req_query_window),
      .req_query_metric    (req_query_metric),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_metric_value    (rsp_metric_value),
      .rsp_query_error     (rsp_query_error),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic counted_read(input logic [OPC_W-1:0] opc);
      return opc inside {OPC_RD6, OPC_RD10, OPC_RD16};
   endfunction

   function automatic logic counted_write(input logic [OPC_W-1:0] opc);
      return opc inside {OPC_WR6, OPC_WR10, OPC_WR16};
   endfunction

   function automatic void clear_totals();
      for (int w = 0; w < NUM_WIN; w++) begin
         win_start[w]    = '0;
         rd_bytes_tot[w] = '0;
         rd_lat_tot[w]   = '0;
         wr_bytes_tot[w] = '0;
         wr_lat_tot[w]   = '0;
      end
   endfunction

   // update every window with one counted completion
   function automatic void record_completion(input logic to_write, input u64_type bytes,
                                             input u64_type lat, input u64_type now);
      u64_type elapsed;
      for (int w = 0; w < NUM_WIN; w++) begin
         elapsed = now - win_start[w];
         if (win_start[w] == '0 || win_start[w] > now) begin
            // restart: start is shared, so the other direction is zeroed too
            win_start[w]    = now;
            rd_bytes_tot[w] = to_write ? '0 : bytes;
            rd_lat_tot[w]   = to_write ? '0 : lat;
            wr_bytes_tot[w] = to_write ? bytes : '0;
            wr_lat_tot[w]   = to_write ? lat : '0;
            elapsed         = '0;
         end else if (to_write) begin
            wr_bytes_tot[w] += bytes;
            wr_lat_tot[w]   += lat;
         end else begin
            rd_bytes_tot[w] += bytes;
            rd_lat_tot[w]   += lat;
         end
         if (elapsed >= win_len[w])
            win_start[w] = '0;
      end
   endfunction

   // apply one accepted word; queries queue their reply
   function automatic void predict_word(input stat_word_type w);
      metric_reply_type r;
      u64_type total;
      u64_type lat;
      lat = w.completion_time - w.issue_time;
      case (w.command)
         CMD_EVENT: begin
            if (mon_enable && counted_read(w.scsi_opcode))
               record_completion(1'b0, u64_type'(w.transfer_length), lat, w.completion_time);
            else if (mon_enable && counted_write(w.scsi_opcode))
               record_completion(1'b1, u64_type'(w.transfer_length), lat, w.completion_time);
         end
         CMD_QUERY: begin
            if (!mon_enable || int'(w.query_window) >= NUM_WIN) begin
               r.metric  = '0;
               r.flagged = 1'b1;
            end else begin
               case (w.query_metric)
                  MET_RD_BYTES: total = rd_bytes_tot[w.query_window];
                  MET_RD_TIME:  total = rd_lat_tot[w.query_window];
                  MET_WR_BYTES: total = wr_bytes_tot[w.query_window];
                  default:      total = wr_lat_tot[w.query_window];
               endcase
               r.metric  = total[TOT_W-1:METRIC_SHIFT];
               r.flagged = 1'b0;
            end
            metric_replies.push_back(r);
         end
         CMD_CLEAR: clear_totals();
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic u64_type rand64();
      return {$urandom, $urandom};
   endfunction

   // idle length: mostly short, a few long
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic void push_word(input logic [CMD_W-1:0] cmd, input logic [OPC_W-1:0] opc,
                                     input logic [XFER_W-1:0] len, input u64_type issue,
                                     input u64_type done, input logic [QSEL_W-1:0] qw,
                                     input logic [QSEL_W-1:0] qm);
      stat_word_type w;
      w.command         = cmd;
      w.scsi_opcode     = opc;
      w.transfer_length = len;
      w.issue_time      = issue;
      w.completion_time = done;
      w.query_window    = qw;
      w.query_metric    = qm;
      pending_words.push_back(w);
   endfunction

   // mostly completions on an advancing time line, with queries, clears and unused commands mixed in
   function automatic stat_word_type random_word(input int unsigned max_step);
      stat_word_type w;
      int unsigned pick;
      w.scsi_opcode     = OPC_W'($urandom);
      w.transfer_length = XFER_W'($urandom);
      w.issue_time      = rand64();
      w.completion_time = rand64();
      w.query_window    = QSEL_W'($urandom);
      w.query_metric    = QSEL_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         w.command = CMD_EVENT;
         if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 5))
               0: w.scsi_opcode = OPC_RD6;
               1: w.scsi_opcode = OPC_RD10;
               2: w.scsi_opcode = OPC_RD16;
               3: w.scsi_opcode = OPC_WR6;
               4: w.scsi_opcode = OPC_WR10;
               default: w.scsi_opcode = OPC_WR16;
            endcase
         end
         if ($urandom_range(0, 1) == 0)
            w.transfer_length = XFER_W'($urandom_range(0, 32'h003F_FFFF));
         // a few events keep fully random times
         if ($urandom_range(0, 99) >= 4) begin
            if ($urandom_range(0, 99) < 4)
               trace_now -= u64_type'($urandom_range(0, 32'd300_000_000));
            else
               trace_now += u64_type'($urandom_range(0, max_step));
            w.completion_time = trace_now;
            if ($urandom_range(0, 9) != 0)
               w.issue_time = trace_now - u64_type'($urandom_range(0, 32'h03FF_FFFF));
         end
      end else if (pick < 95) begin
         w.command = CMD_QUERY;
      end else if (pick < 97) begin
         w.command = CMD_CLEAR;
      end else begin
         w.command = CMD_UNUSED;
      end
      return w;
   endfunction

   task automatic queue_random(input int n, input int unsigned max_step, input logic paced);
      @(negedge clock);
      pace_on = paced;
      for (int i = 0; i < n; i++)
         pending_words.push_back(random_word(max_step));
   endtask

   // wait until every word is out and every reply is back, then let events settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || metric_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input u64_type data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ENABLE)
         mon_enable = data[0];
      else if (idx inside {[CSR_LEN0:CSR_LEN3]})
         win_len[2'(idx - CSR_LEN0)] = data;
      csr_writes++;
   endtask

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         next_gap = gap_left;
         if (req_valid && !req_stall) begin
            predict_word(cur_word);
            words_sent <= words_sent + 1;
            next_gap = (pace_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
         end
         // a stalled word holds still
         if (!(req_valid && req_stall)) begin
            if (next_gap != 0) begin
               gap_left  <= next_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               cur_word = pending_words.pop_front();
               req_command         <= cur_word.command;
               req_scsi_opcode     <= cur_word.scsi_opcode;
               req_transfer_length <= cur_word.transfer_length;
               req_issue_time      <= cur_word.issue_time;
               req_completion_time <= cur_word.completion_time;
               req_query_window    <= cur_word.query_window;
               req_query_metric    <= cur_word.query_metric;
               req_valid           <= 1'b1;
               gap_left            <= 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- long reply hold-off

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && words_sent >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- reply monitor

   always @(posedge clock) begin
      metric_reply_type exp_reply;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_seen++;
            if (metric_replies.size() == 0) begin
               $error("reply with no query pending: metric_value %h query_error %b",
                      rsp_metric_value, rsp_query_error);
               fail_count++;
            end else begin
               exp_reply = metric_replies.pop_front();
               if (exp_reply.flagged)
                  replies_flagged++;
               if (rsp_metric_value !== exp_reply.metric) begin
                  $error("metric_value: expected %h, actual %h",
                         exp_reply.metric, rsp_metric_value);
                  fail_count++;
               end
               if (rsp_query_error !== exp_reply.flagged) begin
                  $error("query_error: expected %b, actual %b",
                         exp_reply.flagged, rsp_query_error);
                  fail_count++;
               end
            end
         end
         // stall pattern
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (pace_on && $urandom_range(0, 99) < 30) begin
            stall_left <= pick_gap() - 1;
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- timeout

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_command         = CMD_EVENT;
      req_scsi_opcode     = '0;
      req_transfer_length = '0;
      req_issue_time      = '0;
      req_completion_time = '0;
      req_query_window    = '0;
      req_query_metric    = '0;
      rsp_stall           = 1'b0;
      csr_valid           = 1'b0;
      csr_index           = CSR_ENABLE;
      csr_wdata           = '0;
      pace_on             = 1'b1;
      gap_left            = 0;
      stall_left          = 0;
      hold_left           = 0;
      hold_done           = 1'b0;
      words_sent          = 0;
      replies_seen        = 0;
      replies_flagged     = 0;
      csr_writes          = 0;
      fail_count          = 0;
      cycle_count         = 0;
      trace_now           = 64'd1000;
      mon_enable          = 1'b1;
      for (int w = 0; w < NUM_WIN; w++)
         win_len[w] = LENGTH_RESET;
      clear_totals();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed words on reset settings
      @(negedge clock);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd0, MET_RD_BYTES);
      push_word(CMD_EVENT, OPC_RD10, 31'h7FFF_FFFF, 64'd1000, 64'd5_000_000, '0, '0);
      // latency wraps: issue after completion
      push_word(CMD_EVENT, OPC_WR10, 31'h7FFF_FFFF, 64'd6_000_000, 64'd5_500_000, '0, '0);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd0, MET_RD_BYTES);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd0, MET_RD_TIME);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd0, MET_WR_BYTES);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd0, MET_WR_TIME);
      // opcodes that are not counted
      push_word(CMD_EVENT, 8'h00, 31'h1234, 64'd0, 64'd6_000_000, '0, '0);
      push_word(CMD_EVENT, 8'hFF, 31'h7FFF_FFFF, 64'd0, 64'd6_000_000, '0, '0);
      push_word(CMD_EVENT, 8'h09, 31'h7FFF_FFFF, 64'd0, 64'd6_000_000, '0, '0);
      // elapsed reaches the length: window closes
      push_word(CMD_EVENT, OPC_RD6, 31'd4096, 64'd5_000_000, 64'd1_005_000_000, '0, '0);
      // closed window restarts and zeroes the read side
      push_word(CMD_EVENT, OPC_WR16, 31'd8_000_000, 64'd1_900_000_000, 64'd2_000_000_000, '0, '0);
      // completion before the start restarts
      push_word(CMD_EVENT, OPC_RD16, 31'd3_000_000, 64'd0, 64'd1_000_000_000, '0, '0);
      push_word(CMD_EVENT, OPC_WR6, 31'd2_000_000, 64'd0, 64'd0, '0, '0);
      push_word(CMD_EVENT, OPC_RD10, 31'h7FFF_FFFF, 64'd0, '1, '0, '0);
      push_word(CMD_EVENT, OPC_WR10, 31'd0, '1, '1, '0, '0);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd3, MET_RD_TIME);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd2, MET_WR_TIME);
      push_word(CMD_UNUSED, OPC_RD6, 31'h7FFF_FFFF, '1, '1, 2'd3, 2'd3);
      push_word(CMD_CLEAR, '0, '0, '0, '0, '0, '0);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd1, MET_RD_BYTES);
      push_word(CMD_QUERY, '0, '0, '0, '0, 2'd3, MET_WR_BYTES);
      wait_idle();

      // long random run on reset lengths; the reply hold-off lands here
      queue_random(500, 60_000_000, 1'b1);
      wait_idle();

      // extreme lengths, no idling on either side
      write_csr(CSR_LEN0, 64'd0);
      write_csr(CSR_LEN1, '1);
      write_csr(CSR_LEN2, 64'd1);
      write_csr(CSR_LEN3, 64'd300_000_000);
      queue_random(250, 200_000_000, 1'b0);
      wait_idle();

      // monitoring off: events dropped, queries flagged, clear still acts
      write_csr(CSR_ENABLE, 64'd0);
      queue_random(60, 60_000_000, 1'b1);
      wait_idle();

      // back on with random lengths; an out-of-range index is dropped
      write_csr(CSR_ENABLE, 64'd1);
      write_csr(CSR_LEN0, u64_type'($urandom_range(1, 32'd400_000_000)));
      write_csr(CSR_LEN1, u64_type'($urandom_range(1, 32'd400_000_000)));
      write_csr(CSR_LEN2, u64_type'($urandom));
      write_csr(CSR_LEN3, u64_type'($urandom_range(1, 32'd100_000_000)));
      write_csr(CSR_NONE, rand64());
      queue_random(250, 100_000_000, 1'b1);
      wait_idle();

      $display("Run covered %0d request words and %0d register writes over %0d cycles;",
               words_sent, csr_writes, cycle_count);
      $display("%0d query replies checked, %0d of them flagged, %0d mismatches.",
               replies_seen, replies_flagged, fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
